// ===== rtl/mpf_pkg.sv =====
`default_nettype none

package mpf_pkg;

    // Fixed field widths of the item and result beats
    localparam int OP_W        = 2;
    localparam int PRIO_W      = 4;
    localparam int VALUE_W     = 32;
    localparam int TOTAL_W     = 8;
    localparam int LEVEL_CNT_W = 5;
    localparam int STATUS_W    = 2;

    // Operation codes
    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_PEEK   = 2'd2;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_BADPRIO = 2'd3
    } mpf_status_t;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_EXEC   = 2'd1,
        S_LOOKUP = 2'd2,
        S_DONE   = 2'd3
    } mpf_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load_in;
        logic exec;
        logic lookup;
        logic load_out;
    } mpf_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic out_free;
    } mpf_stat_t;

endpackage

`default_nettype wire

// ===== rtl/mpf_ctrl.sv =====
`default_nettype none

module mpf_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire mpf_pkg::mpf_stat_t stat,
    output mpf_pkg::mpf_cmd_t     cmd
);

    mpf_pkg::mpf_state_t state_reg;
    mpf_pkg::mpf_state_t state_next;

    // Hold the current step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mpf_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Advance through update, head lookup and result load
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mpf_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = mpf_pkg::S_EXEC;
                end
            end
            mpf_pkg::S_EXEC:
            begin
                state_next = mpf_pkg::S_LOOKUP;
            end
            mpf_pkg::S_LOOKUP:
            begin
                state_next = mpf_pkg::S_DONE;
            end
            mpf_pkg::S_DONE:
            begin
                if (stat.out_free)
                begin
                    state_next = mpf_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = mpf_pkg::S_IDLE;
            end
        endcase
    end

    // Drive datapath commands and the input handshake
    always_comb
    begin
        in_ready     = 1'b0;
        cmd          = '0;
        case (state_reg)
            mpf_pkg::S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
            end
            mpf_pkg::S_EXEC:
            begin
                cmd.exec = 1'b1;
            end
            mpf_pkg::S_LOOKUP:
            begin
                cmd.lookup = 1'b1;
            end
            mpf_pkg::S_DONE:
            begin
                cmd.load_out = stat.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/mpf_datapath.sv =====
`default_nettype none

module mpf_datapath #(
    parameter int NUM_LEVELS  = 8,
    parameter int LEVEL_DEPTH = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire mpf_pkg::mpf_cmd_t                     cmd,
    output mpf_pkg::mpf_stat_t                         stat,
    input  wire logic [mpf_pkg::OP_W-1:0]              operation,
    input  wire logic [mpf_pkg::PRIO_W-1:0]            task_priority,
    input  wire logic signed [mpf_pkg::VALUE_W-1:0]    task_value,
    input  wire logic                                  out_ready,
    output logic                                       out_valid,
    output logic signed [mpf_pkg::VALUE_W-1:0]         head_value,
    output logic [mpf_pkg::PRIO_W-1:0]                 head_priority,
    output logic                                       store_empty,
    output logic [mpf_pkg::TOTAL_W-1:0]                total_items,
    output logic [mpf_pkg::LEVEL_CNT_W-1:0]            level_items,
    output logic [mpf_pkg::STATUS_W-1:0]               status
);

    localparam int LVL_W  = $clog2(NUM_LEVELS);
    localparam int HP_W   = $clog2(NUM_LEVELS + 1);
    localparam int PTR_W  = $clog2(LEVEL_DEPTH);
    localparam int CNT_W  = $clog2(LEVEL_DEPTH + 1);
    localparam int MEM_D  = NUM_LEVELS * LEVEL_DEPTH;
    localparam int ADDR_W = $clog2(MEM_D);
    localparam int TOT_W  = $clog2(MEM_D + 1);

    // Captured item
    logic [mpf_pkg::OP_W-1:0]           op_reg;
    logic [mpf_pkg::PRIO_W-1:0]         prio_reg;
    logic [mpf_pkg::VALUE_W-1:0]        value_reg;

    // Per-level queue state
    logic [PTR_W-1:0] head_reg  [NUM_LEVELS];
    logic [PTR_W-1:0] head_next [NUM_LEVELS];
    logic [PTR_W-1:0] tail_reg  [NUM_LEVELS];
    logic [PTR_W-1:0] tail_next [NUM_LEVELS];
    logic [CNT_W-1:0] count_reg  [NUM_LEVELS];
    logic [CNT_W-1:0] count_next [NUM_LEVELS];
    logic [TOT_W-1:0] total_reg;
    logic [TOT_W-1:0] total_next;

    // Entry store
    logic [mpf_pkg::VALUE_W-1:0] mem [MEM_D];
    logic [mpf_pkg::VALUE_W-1:0] rd_data_reg;
    logic                        rd_en;
    logic [ADDR_W-1:0]           rd_addr;
    logic                        wr_en;
    logic [ADDR_W-1:0]           wr_addr;

    // Per-item result state
    mpf_pkg::mpf_status_t status_reg;
    mpf_pkg::mpf_status_t status_next;
    logic [HP_W-1:0]      hp_reg;
    logic [HP_W-1:0]      hp_next;
    logic                 removed_reg;

    // Output register
    logic                                out_valid_reg;
    logic [mpf_pkg::VALUE_W-1:0]         out_value_reg;
    logic [mpf_pkg::PRIO_W-1:0]          out_prio_reg;
    logic                                out_empty_reg;
    logic [mpf_pkg::TOTAL_W-1:0]         out_total_reg;
    logic [mpf_pkg::LEVEL_CNT_W-1:0]     out_level_reg;
    logic [mpf_pkg::STATUS_W-1:0]        out_status_reg;

    // Decoded item and encoder results
    logic             prio_ok;
    logic [LVL_W-1:0] lvl;
    logic             top_found;
    logic [LVL_W-1:0] top_idx;
    logic             add_ok;
    logic             rem_ok;

    function automatic logic [ADDR_W-1:0] slot_addr(input logic [LVL_W-1:0] l,
                                                    input logic [PTR_W-1:0] p);
        slot_addr = ADDR_W'(ADDR_W'(l) * ADDR_W'(LEVEL_DEPTH) + ADDR_W'(p));
    endfunction

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        wrap_inc = (p == PTR_W'(LEVEL_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Decode the item's level
    assign prio_ok = (prio_reg != '0) && (32'(prio_reg) <= 32'(NUM_LEVELS));
    assign lvl     = LVL_W'(prio_reg - 1'b1);

    // Priority encode the highest non-empty level from the live counts
    always_comb
    begin
        top_found = 1'b0;
        top_idx   = '0;
        for (int i = 0; i < NUM_LEVELS; i++)
        begin
            if (count_reg[i] != '0)
            begin
                top_found = 1'b1;
                top_idx   = LVL_W'(i);
            end
        end
    end

    assign add_ok = (op_reg == mpf_pkg::OP_ADD) && prio_ok
                    && (count_reg[lvl] != CNT_W'(LEVEL_DEPTH));
    assign rem_ok = (op_reg == mpf_pkg::OP_REMOVE) && top_found;

    // Update queue pointers and counts on the execute step
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        total_next = total_reg;
        if (cmd.exec)
        begin
            if (add_ok)
            begin
                tail_next[lvl]  = wrap_inc(tail_reg[lvl]);
                count_next[lvl] = count_reg[lvl] + 1'b1;
                total_next      = total_reg + 1'b1;
            end
            else if (rem_ok)
            begin
                head_next[top_idx]  = wrap_inc(head_reg[top_idx]);
                count_next[top_idx] = count_reg[top_idx] - 1'b1;
                total_next          = total_reg - 1'b1;
            end
        end
    end

    // Pick status and head priority
    always_comb
    begin
        status_next = status_reg;
        hp_next     = hp_reg;
        if (cmd.exec)
        begin
            status_next = mpf_pkg::ST_OK;
            hp_next     = '0;
            if (op_reg == mpf_pkg::OP_ADD)
            begin
                if (!prio_ok)
                begin
                    status_next = mpf_pkg::ST_BADPRIO;
                end
                else if (!add_ok)
                begin
                    status_next = mpf_pkg::ST_FULL;
                end
            end
            else if (op_reg == mpf_pkg::OP_REMOVE)
            begin
                if (rem_ok)
                begin
                    hp_next = HP_W'(top_idx) + 1'b1;
                end
                else
                begin
                    status_next = mpf_pkg::ST_EMPTY;
                end
            end
        end
        else if (cmd.lookup && !removed_reg)
        begin
            hp_next = top_found ? HP_W'(top_idx) + 1'b1 : '0;
        end
    end

    // Read the removed entry on execute, or the new head on lookup
    assign rd_en   = (cmd.exec && rem_ok) || (cmd.lookup && !removed_reg && top_found);
    assign rd_addr = slot_addr(top_idx, head_reg[top_idx]);
    assign wr_en   = cmd.exec && add_ok;
    assign wr_addr = slot_addr(lvl, tail_reg[lvl]);

    // Entry store with registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= value_reg;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Capture the accepted item
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg    <= operation;
            prio_reg  <= task_priority;
            value_reg <= task_value;
        end
    end

    // Hold queue state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LEVELS; i++)
            begin
                head_reg[i]  <= '0;
                tail_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
            total_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            total_reg <= total_next;
        end
    end

    // Hold per-item result state
    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        hp_reg     <= hp_next;
        if (cmd.exec)
        begin
            removed_reg <= (op_reg == mpf_pkg::OP_REMOVE);
        end
    end

    // Output beat valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output beat payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_value_reg  <= (hp_reg != '0) ? rd_data_reg : '0;
            out_prio_reg   <= mpf_pkg::PRIO_W'(hp_reg);
            out_empty_reg  <= (total_reg == '0);
            out_total_reg  <= mpf_pkg::TOTAL_W'(total_reg);
            out_level_reg  <= prio_ok ? mpf_pkg::LEVEL_CNT_W'(count_reg[lvl]) : '0;
            out_status_reg <= status_reg;
        end
    end

    assign stat.out_free = !out_valid_reg || out_ready;

    assign out_valid     = out_valid_reg;
    assign head_value    = out_value_reg;
    assign head_priority = out_prio_reg;
    assign store_empty   = out_empty_reg;
    assign total_items   = out_total_reg;
    assign level_items   = out_level_reg;
    assign status        = out_status_reg;

endmodule

`default_nettype wire

// ===== rtl/multilevel_priority_fifo_core.sv =====
// Sequence: an accepted item passes through update, head lookup through the entry store's
//   registered read, and result load before its result beat is presented.
// Flow: the controller takes a new item only when idle, after the previous result is loaded;
//   a result stalled in the output register blocks the next item's work until it is taken.
// Reset: rst_n is asynchronous active low; it empties every level and clears control.
//   Entry store contents are not reset.
`default_nettype none

module multilevel_priority_fifo_core #(
    parameter int NUM_LEVELS  = 8,
    parameter int LEVEL_DEPTH = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic [mpf_pkg::OP_W-1:0]              operation,
    input  wire logic [mpf_pkg::PRIO_W-1:0]            task_priority,
    input  wire logic signed [mpf_pkg::VALUE_W-1:0]    task_value,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic signed [mpf_pkg::VALUE_W-1:0]         head_value,
    output logic [mpf_pkg::PRIO_W-1:0]                 head_priority,
    output logic                                       store_empty,
    output logic [mpf_pkg::TOTAL_W-1:0]                total_items,
    output logic [mpf_pkg::LEVEL_CNT_W-1:0]            level_items,
    output logic [mpf_pkg::STATUS_W-1:0]               status
);

    mpf_pkg::mpf_cmd_t  cmd;
    mpf_pkg::mpf_stat_t stat;

    mpf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mpf_datapath #(
        .NUM_LEVELS  (NUM_LEVELS),
        .LEVEL_DEPTH (LEVEL_DEPTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .operation     (operation),
        .task_priority (task_priority),
        .task_value    (task_value),
        .out_ready     (out_ready),
        .out_valid     (out_valid),
        .head_value    (head_value),
        .head_priority (head_priority),
        .store_empty   (store_empty),
        .total_items   (total_items),
        .level_items   (level_items),
        .status        (status)
    );

endmodule

`default_nettype wire

// ===== rtl/mpf_checker.sv =====
`default_nettype none

module mpf_checker #(
    parameter int LEVEL_DEPTH = 16
) (
    input wire logic                                  clk,
    input wire logic                                  rst_n,
    input wire logic                                  in_valid,
    input wire logic                                  in_ready,
    input wire logic                                  out_valid,
    input wire logic                                  out_ready,
    input wire logic signed [mpf_pkg::VALUE_W-1:0]    head_value,
    input wire logic [mpf_pkg::PRIO_W-1:0]            head_priority,
    input wire logic                                  store_empty,
    input wire logic [mpf_pkg::TOTAL_W-1:0]           total_items,
    input wire logic [mpf_pkg::LEVEL_CNT_W-1:0]       level_items,
    input wire logic [mpf_pkg::STATUS_W-1:0]          status
);

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(head_value) && $stable(status))
        else $error("result beat changed while stalled");

    // One item in work at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("item accepted while another is in work");

    // Empty flag agrees with the total count
    a_empty_total: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (store_empty == (total_items == '0)))
        else $error("empty flag disagrees with total count");

    // A beat with no head reports a zero value
    a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (head_priority == '0) |-> (head_value == '0))
        else $error("missing head reports a value");

    // A dropped add reports a full level
    a_full_level: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == mpf_pkg::ST_FULL)
        |-> (level_items == mpf_pkg::LEVEL_CNT_W'(LEVEL_DEPTH)))
        else $error("full status without a full level");

endmodule

bind multilevel_priority_fifo_core mpf_checker #(.LEVEL_DEPTH(LEVEL_DEPTH)) u_mpf_checker (.*);

`default_nettype wire

// ===== tb/tb_multilevel_priority_fifo_core.sv =====
`default_nettype none

module tb_multilevel_priority_fifo_core;

    localparam int NUM_LEVELS  = 8;
    localparam int LEVEL_DEPTH = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 7;
    localparam int PHASE_BEATS = 100;

    // Operation code 3 is unassigned and behaves as a peek
    localparam logic [mpf_pkg::OP_W-1:0] OP_SPARE = 2'd3;

    localparam logic signed [mpf_pkg::VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
    localparam logic signed [mpf_pkg::VALUE_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;

    logic                                   clk;
    logic                                   rst_n;
    logic                                   in_valid;
    logic                                   in_ready;
    logic [mpf_pkg::OP_W-1:0]               operation;
    logic [mpf_pkg::PRIO_W-1:0]             task_priority;
    logic signed [mpf_pkg::VALUE_W-1:0]     task_value;
    logic                                   out_valid;
    logic                                   out_ready;
    logic signed [mpf_pkg::VALUE_W-1:0]     head_value;
    logic [mpf_pkg::PRIO_W-1:0]             head_priority;
    logic                                   store_empty;
    logic [mpf_pkg::TOTAL_W-1:0]            total_items;
    logic [mpf_pkg::LEVEL_CNT_W-1:0]        level_items;
    logic [mpf_pkg::STATUS_W-1:0]           status;

    bit quiet_tail;
    int cycles = 0;

    // Expected contents of one result beat
    typedef struct {
        logic signed [mpf_pkg::VALUE_W-1:0] head_value;
        logic [mpf_pkg::PRIO_W-1:0]         head_priority;
        logic                               store_empty;
        logic [mpf_pkg::TOTAL_W-1:0]        total_items;
        logic [mpf_pkg::LEVEL_CNT_W-1:0]    level_items;
        mpf_pkg::mpf_status_t               status;
    } head_report_t;

    // Shadow of the per-level queues plus the reports still owed by the block
    class level_queue_shadow;
        logic signed [mpf_pkg::VALUE_W-1:0] level_q[NUM_LEVELS][$];
        int                                 held_total;
        head_report_t                       pending_reports[$];
        int                                 failures;

        function int top_level();
            for (int i = NUM_LEVELS - 1; i >= 0; i--)
            begin
                if (level_q[i].size() != 0)
                    return i;
            end
            return -1;
        endfunction

        function int outstanding();
            return pending_reports.size();
        endfunction

        // Apply one accepted beat to the shadow and queue the report it yields
        function void absorb_item(logic [mpf_pkg::OP_W-1:0] op,
                                  logic [mpf_pkg::PRIO_W-1:0] prio,
                                  logic signed [mpf_pkg::VALUE_W-1:0] val);
            head_report_t r;
            bit           prio_ok;
            bit           took_head;
            int           top;
            prio_ok         = (prio >= 1) && (prio <= NUM_LEVELS);
            took_head       = 1'b0;
            r.head_value    = '0;
            r.head_priority = '0;
            r.status        = mpf_pkg::ST_OK;

            if (op == mpf_pkg::OP_ADD)
            begin
                if (!prio_ok)
                    r.status = mpf_pkg::ST_BADPRIO;
                else if (level_q[prio - 1].size() >= LEVEL_DEPTH)
                    r.status = mpf_pkg::ST_FULL;
                else
                begin
                    level_q[prio - 1].push_back(val);
                    held_total++;
                end
            end
            else if (op == mpf_pkg::OP_REMOVE)
            begin
                top       = top_level();
                took_head = 1'b1;
                if (top < 0)
                    r.status = mpf_pkg::ST_EMPTY;
                else
                begin
                    r.head_value    = level_q[top].pop_front();
                    r.head_priority = mpf_pkg::PRIO_W'(top + 1);
                    held_total--;
                end
            end

            // Report the surviving head unless a remove already supplied one
            if (!took_head)
            begin
                top = top_level();
                if (top >= 0)
                begin
                    r.head_value    = level_q[top][0];
                    r.head_priority = mpf_pkg::PRIO_W'(top + 1);
                end
            end

            r.level_items = '0;
            if (prio_ok)
                r.level_items = mpf_pkg::LEVEL_CNT_W'(level_q[prio - 1].size());
            r.total_items = mpf_pkg::TOTAL_W'(held_total);
            r.store_empty = (held_total == 0);
            pending_reports.push_back(r);
        endfunction

        // Compare one result beat against the oldest owed report
        function void check_report(logic signed [mpf_pkg::VALUE_W-1:0] hv,
                                   logic [mpf_pkg::PRIO_W-1:0] hp,
                                   logic emp, logic [mpf_pkg::TOTAL_W-1:0] tot,
                                   logic [mpf_pkg::LEVEL_CNT_W-1:0] lvl,
                                   logic [mpf_pkg::STATUS_W-1:0] st);
            head_report_t want;
            if (pending_reports.size() == 0)
            begin
                $error("result beat with no item outstanding");
                failures++;
                return;
            end
            want = pending_reports.pop_front();
            if (hv !== want.head_value)
            begin
                $error("head_value: expected %0d, actual %0d", want.head_value, hv);
                failures++;
            end
            if (hp !== want.head_priority)
            begin
                $error("head_priority: expected %0d, actual %0d", want.head_priority, hp);
                failures++;
            end
            if (emp !== want.store_empty)
            begin
                $error("store_empty: expected %0d, actual %0d", want.store_empty, emp);
                failures++;
            end
            if (tot !== want.total_items)
            begin
                $error("total_items: expected %0d, actual %0d", want.total_items, tot);
                failures++;
            end
            if (lvl !== want.level_items)
            begin
                $error("level_items: expected %0d, actual %0d", want.level_items, lvl);
                failures++;
            end
            if (st !== want.status)
            begin
                $error("status: expected %0d, actual %0d", want.status, st);
                failures++;
            end
        endfunction
    endclass

    level_queue_shadow board = new();

    multilevel_priority_fifo_core #(
        .NUM_LEVELS  (NUM_LEVELS),
        .LEVEL_DEPTH (LEVEL_DEPTH)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .operation     (operation),
        .task_priority (task_priority),
        .task_value    (task_value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .head_value    (head_value),
        .head_priority (head_priority),
        .store_empty   (store_empty),
        .total_items   (total_items),
        .level_items   (level_items),
        .status        (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_multilevel_priority_fifo_core: errors");
            $finish;
        end
    end

    // Pick a task value, leaning on the two extremes now and then
    function automatic logic signed [mpf_pkg::VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return VALUE_MIN;
            1:       return VALUE_MAX;
            default: return $urandom;
        endcase
    endfunction

    // Drop valid for a random burst between beats
    task automatic hold_off();
        if (!quiet_tail && $urandom_range(0, 99) < 12)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
    endtask

    // Present one beat and hold it until accepted
    task automatic send_item(input logic [mpf_pkg::OP_W-1:0] op,
                             input logic [mpf_pkg::PRIO_W-1:0] prio,
                             input logic signed [mpf_pkg::VALUE_W-1:0] val);
        hold_off();
        in_valid      <= 1'b1;
        operation     <= op;
        task_priority <= prio;
        task_value    <= val;
        do
            @(posedge clk);
        while (!(in_valid && in_ready));
        board.absorb_item(op, prio, val);
    endtask

    // Drop valid and wait for every owed report to come back
    task automatic drain_reports();
        in_valid <= 1'b0;
        while (board.outstanding() != 0)
            @(posedge clk);
    endtask

    // Result side: check accepted beats, stall ready in random bursts
    initial
    begin
        int stall_left;
        stall_left = 0;
        out_ready <= 1'b0;
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                board.check_report(head_value, head_priority, store_empty,
                                   total_items, level_items, status);
            if (stall_left == 0 && !quiet_tail && $urandom_range(0, 99) < 7)
                stall_left = $urandom_range(1, 16);
            out_ready <= (stall_left == 0);
            if (stall_left > 0)
                stall_left--;
        end
    end

    initial
    begin
        int add_pct;
        int lo;
        int hi;
        int pick;
        quiet_tail    = 1'b0;
        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        operation     <= mpf_pkg::OP_PEEK;
        task_priority <= '0;
        task_value    <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty store, bad priorities, spare opcode, extremes, full level
        send_item(mpf_pkg::OP_PEEK,   4'd0,  32'sd0);
        send_item(mpf_pkg::OP_REMOVE, 4'd15, 32'sd7);
        send_item(mpf_pkg::OP_ADD,    4'd0,  32'sd5);
        send_item(mpf_pkg::OP_ADD,    4'd9,  -32'sd100);
        send_item(mpf_pkg::OP_ADD,    4'd15, VALUE_MAX);
        send_item(OP_SPARE,           4'd3,  32'sd1);
        send_item(mpf_pkg::OP_ADD,    4'd1,  VALUE_MIN);
        send_item(mpf_pkg::OP_ADD,    4'd8,  VALUE_MAX);
        send_item(mpf_pkg::OP_PEEK,   4'd8,  32'sd0);
        send_item(mpf_pkg::OP_ADD,    4'd8,  32'sd0);
        send_item(mpf_pkg::OP_REMOVE, 4'd1,  32'sd0);
        send_item(mpf_pkg::OP_ADD,    4'd4,  -32'sd1);
        send_item(mpf_pkg::OP_REMOVE, 4'd9,  32'sd0);
        for (int i = 0; i < LEVEL_DEPTH - 1; i++)
            send_item(mpf_pkg::OP_ADD, 4'd1,
                      i[0] ? (32'sh5555_5555 ^ i) : (32'shAAAA_AAAA ^ i));
        send_item(mpf_pkg::OP_ADD, 4'd1, 32'sd42);
        drain_reports();

        // Random phases alternating fill-heavy and drain-heavy traffic
        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph == PHASES - 1)
                quiet_tail = 1'b1;
            add_pct = ph[0] ? $urandom_range(15, 40) : $urandom_range(60, 85);
            lo      = $urandom_range(1, NUM_LEVELS);
            hi      = lo + $urandom_range(0, NUM_LEVELS - 1);
            if (hi > NUM_LEVELS)
                hi = NUM_LEVELS;
            for (int n = 0; n < PHASE_BEATS; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 4)
                    send_item(mpf_pkg::OP_W'($urandom_range(0, 3)),
                              mpf_pkg::PRIO_W'($urandom_range(0, 15)), pick_value());
                else if (pick < 10)
                    send_item(pick[0] ? OP_SPARE : mpf_pkg::OP_PEEK,
                              mpf_pkg::PRIO_W'($urandom_range(0, 15)), pick_value());
                else if (pick < 10 + (add_pct * 90) / 100)
                    send_item(mpf_pkg::OP_ADD, mpf_pkg::PRIO_W'($urandom_range(lo, hi)),
                              pick_value());
                else
                    send_item(mpf_pkg::OP_REMOVE, mpf_pkg::PRIO_W'($urandom_range(0, 15)),
                              pick_value());
            end
            // Let the block run dry between some phases
            if (ph[0])
                drain_reports();
        end

        drain_reports();
        repeat (8) @(posedge clk);
        if (board.failures == 0 && board.outstanding() == 0)
            $display("tb_multilevel_priority_fifo_core: clean");
        else
            $display("tb_multilevel_priority_fifo_core: errors");
        $finish;
    end

endmodule

`default_nettype wire
